FILE: hdl/pwlh_pkg.sv
// Shared types, constants and functions of the pulse-width log histogram.
package pwlh_pkg;

  localparam int unsigned NumBinsDef   = 320;
  localparam int unsigned DataW        = 32;
  localparam int unsigned BinW         = 9;
  localparam int unsigned HeightW      = 7;
  localparam int unsigned BlenW        = 6;
  localparam int unsigned InTdataW     = 48;
  localparam int unsigned InTuserW     = 3;
  localparam int unsigned OutTdataW    = 40;

  localparam int unsigned BinMantMask  = 'h0f;
  localparam int unsigned BinOffset    = 64;
  localparam int unsigned BinScale     = 16;
  localparam int unsigned BinMin       = 5;
  localparam int unsigned HeightOffset = 8;
  localparam int unsigned HeightMax    = 100;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDADDR,
    ST_RDDATA,
    ST_BLEN,
    ST_BIN,
    ST_INC,
    ST_HEIGHT
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_we;
    logic load_count;
    logic blen_en;
    logic rd_bin;
    logic inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_read;
    logic out_stall;
  } stat_t;

  function automatic logic [3:0] bit_length8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [BlenW-1:0] bit_length32(input logic [DataW-1:0] v);
    logic [BlenW-1:0] n;
    n = '0;
    for (int k = 0; k < 4; k++) begin
      if (v[8*k +: 8] != 8'd0) begin
        n = BlenW'(8 * k) + BlenW'(bit_length8(v[8*k +: 8]));
      end
    end
    return n;
  endfunction

endpackage

FILE: hdl/pulse_width_log_histogram.sv
// Top level of the pulse-width log histogram with stream ports.
// An add transaction steps the controller through BLEN, BIN and INC; a read through RDADDR,
// RDDATA, BLEN and HEIGHT, its result loaded into the output register from HEIGHT once the
// previous result has been taken; a no-op returns straight to idle.
// These sequences are set by the controller around the registered-read counter RAMs.
// A clear transaction runs the clearing pass: one RAM entry of each store is zeroed per cycle.
// After reset the same clearing pass runs with tready low, and the phase is zero.
module pulse_width_log_histogram #(
  parameter int unsigned NumBins = pwlh_pkg::NumBinsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // sample_word [31:0], bin_index [40:32], zero padding [47:41]
  input  logic [pwlh_pkg::InTdataW-1:0]     s_axis_tdata_i,
  // opcode [1:0], table_select [2]
  input  logic [pwlh_pkg::InTuserW-1:0]     s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // bin_count [31:0], bar_height [38:32], zero padding [39]
  output logic [pwlh_pkg::OutTdataW-1:0]    m_axis_tdata_o
);

  pwlh_pkg::cmd_t                  cmd;
  pwlh_pkg::stat_t                 stat;
  pwlh_pkg::op_e                   in_op;
  logic [pwlh_pkg::DataW-1:0]      out_count;
  logic [pwlh_pkg::HeightW-1:0]    out_height;

  assign in_op = pwlh_pkg::op_e'(s_axis_tuser_i[1:0]);

  pwlh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_op_i   (in_op),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pwlh_datapath #(
    .NumBins(NumBins)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (in_op),
    .in_word_i   (s_axis_tdata_i[31:0]),
    .in_idx_i    (s_axis_tdata_i[40:32]),
    .in_sel_i    (s_axis_tuser_i[2]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_count_o (out_count),
    .out_height_o(out_height)
  );

  assign m_axis_tdata_o = {1'b0, out_height, out_count};

  // No transaction is taken while a store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_we |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");

  // Any accepted operation other than a no-op keeps the input closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (in_op != pwlh_pkg::OP_NONE))
    |=> !s_axis_tready_o)
    else $error("input reopened while an operation is in progress");

  // The output register is only loaded when it is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("pending result overwritten");

  // A read result never appears on the cycle right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (in_op == pwlh_pkg::OP_READ))
    |=> !cmd.out_load)
    else $error("read result loaded before the count was fetched");

endmodule

FILE: hdl/pwlh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pwlh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 320,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pwlh_datapath.sv
// Datapath: bin mapping, bar height, counter stores, clear counter and output register.
module pwlh_datapath #(
  parameter int unsigned NumBins = pwlh_pkg::NumBinsDef,
  localparam int unsigned AddrW = $clog2(NumBins)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pwlh_pkg::cmd_t                  cmd_i,
  output pwlh_pkg::stat_t                 stat_o,
  input  pwlh_pkg::op_e                   in_op_i,
  input  logic [pwlh_pkg::DataW-1:0]      in_word_i,
  input  logic [pwlh_pkg::BinW-1:0]       in_idx_i,
  input  logic                            in_sel_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [pwlh_pkg::DataW-1:0]      out_count_o,
  output logic [pwlh_pkg::HeightW-1:0]    out_height_o
);

  logic                             op_read_q;
  logic                             sel_q;
  logic [pwlh_pkg::BinW-1:0]        idx_q;
  logic [pwlh_pkg::DataW-1:0]       opnd_q, opnd_d;
  logic [pwlh_pkg::BlenW-1:0]       blen_q;
  logic [AddrW-1:0]                 bin_q;
  logic                             bin_ok_q;
  logic                             phase_q, phase_d;
  logic [AddrW-1:0]                 clr_q, clr_d;
  logic                             out_valid_q, out_valid_d;
  logic [pwlh_pkg::DataW-1:0]       out_count_q;
  logic [pwlh_pkg::HeightW-1:0]     out_height_q;

  logic [pwlh_pkg::DataW-1:0]       high_rd, low_rd, count;
  logic                             idx_ok;
  logic                             clr_last;
  logic [pwlh_pkg::BlenW-1:0]       bin_sh, h_sh;
  logic [3:0]                       bin_mant;
  logic [1:0]                       h_mant;
  logic [9:0]                       bin;
  logic                             bin_ok;
  logic [7:0]                       h_raw, h_inc;
  logic [pwlh_pkg::HeightW-1:0]     height;
  logic                             high_we, low_we;
  logic [AddrW-1:0]                 waddr, raddr;
  logic [pwlh_pkg::DataW-1:0]       wdata;

  assign idx_ok   = 10'(idx_q) < 10'(NumBins);
  assign count    = idx_ok ? (sel_q ? low_rd : high_rd) : '0;
  assign clr_last = clr_q == AddrW'(NumBins - 1);

  always_comb begin
    bin_sh   = pwlh_pkg::BlenW'(blen_q - pwlh_pkg::BlenW'(pwlh_pkg::BinMin));
    bin_mant = 4'((opnd_q >> bin_sh) & pwlh_pkg::DataW'(pwlh_pkg::BinMantMask));
    if (blen_q >= pwlh_pkg::BlenW'(pwlh_pkg::BinMin)) begin
      bin = 10'(10'(blen_q) * 10'(pwlh_pkg::BinScale)) + 10'(bin_mant)
            - 10'(pwlh_pkg::BinOffset);
    end else begin
      bin = 10'(opnd_q[4:0]);
    end
    bin_ok = (bin >= 10'(pwlh_pkg::BinMin)) && (bin < 10'(NumBins));
  end

  always_comb begin
    h_sh   = pwlh_pkg::BlenW'(blen_q - pwlh_pkg::BlenW'(3));
    h_mant = 2'(opnd_q >> h_sh);
    if (blen_q >= pwlh_pkg::BlenW'(3)) begin
      h_raw = 8'({2'b00, blen_q} << 2) + 8'(h_mant) - 8'(pwlh_pkg::HeightOffset);
    end else begin
      h_raw = 8'(opnd_q[1:0]);
    end
    h_inc = h_raw + 8'd1;
    if (h_inc > 8'(pwlh_pkg::HeightMax)) begin
      height = pwlh_pkg::HeightW'(pwlh_pkg::HeightMax);
    end else begin
      height = h_inc[pwlh_pkg::HeightW-1:0];
    end
  end

  always_comb begin
    high_we = cmd_i.clr_we || (cmd_i.inc && bin_ok_q && !phase_q);
    low_we  = cmd_i.clr_we || (cmd_i.inc && bin_ok_q && phase_q);
    waddr   = cmd_i.clr_we ? clr_q : bin_q;
    wdata   = cmd_i.clr_we ? '0 : ((phase_q ? low_rd : high_rd) + pwlh_pkg::DataW'(1));
    raddr   = cmd_i.rd_bin ? bin[AddrW-1:0] : idx_q[AddrW-1:0];
  end

  pwlh_ram #(
    .Width(pwlh_pkg::DataW),
    .Depth(NumBins)
  ) u_high_ram (
    .clk_i  (clk_i),
    .we_i   (high_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(high_rd)
  );

  pwlh_ram #(
    .Width(pwlh_pkg::DataW),
    .Depth(NumBins)
  ) u_low_ram (
    .clk_i  (clk_i),
    .we_i   (low_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(low_rd)
  );

  always_comb begin
    opnd_d = opnd_q;
    if (cmd_i.accept) begin
      opnd_d = pwlh_pkg::DataW'(0) - in_word_i;
    end else if (cmd_i.load_count) begin
      opnd_d = count;
    end

    clr_d = clr_q;
    if (cmd_i.clr_start) begin
      clr_d = '0;
    end else if (cmd_i.clr_we) begin
      clr_d = clr_last ? '0 : AddrW'(clr_q + AddrW'(1));
    end

    phase_d = phase_q;
    if (cmd_i.clr_start) begin
      phase_d = 1'b0;
    end else if (cmd_i.inc) begin
      phase_d = ~phase_q;
    end

    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    if (cmd_i.accept) begin
      op_read_q <= in_op_i == pwlh_pkg::OP_READ;
      sel_q     <= in_sel_i;
      idx_q     <= in_idx_i;
    end
    if (cmd_i.blen_en) begin
      blen_q <= pwlh_pkg::bit_length32(opnd_q);
    end
    if (cmd_i.rd_bin) begin
      bin_q    <= bin[AddrW-1:0];
      bin_ok_q <= bin_ok;
    end
    if (cmd_i.out_load) begin
      out_count_q  <= opnd_q;
      out_height_q <= height;
    end
  end

  assign stat_o.clr_last  = clr_last;
  assign stat_o.op_read   = op_read_q;
  assign stat_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_count_o  = out_count_q;
  assign out_height_o = out_height_q;

endmodule

FILE: hdl/pwlh_ctrl.sv
// Controller state machine that sequences clear passes, sample updates and bin reads.
module pwlh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  pwlh_pkg::op_e   in_op_i,
  output logic            in_ready_o,
  input  pwlh_pkg::stat_t stat_i,
  output pwlh_pkg::cmd_t  cmd_o
);

  pwlh_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pwlh_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = pwlh_pkg::ST_IDLE;
        end
      end
      pwlh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            pwlh_pkg::OP_ADD:   state_d = pwlh_pkg::ST_BLEN;
            pwlh_pkg::OP_READ:  state_d = pwlh_pkg::ST_RDADDR;
            pwlh_pkg::OP_CLEAR: state_d = pwlh_pkg::ST_CLEAR;
            default:            state_d = pwlh_pkg::ST_IDLE;
          endcase
        end
      end
      pwlh_pkg::ST_RDADDR: state_d = pwlh_pkg::ST_RDDATA;
      pwlh_pkg::ST_RDDATA: state_d = pwlh_pkg::ST_BLEN;
      pwlh_pkg::ST_BLEN: begin
        state_d = stat_i.op_read ? pwlh_pkg::ST_HEIGHT : pwlh_pkg::ST_BIN;
      end
      pwlh_pkg::ST_BIN: state_d = pwlh_pkg::ST_INC;
      pwlh_pkg::ST_INC: state_d = pwlh_pkg::ST_IDLE;
      pwlh_pkg::ST_HEIGHT: begin
        if (!stat_i.out_stall) begin
          state_d = pwlh_pkg::ST_IDLE;
        end
      end
      default: state_d = pwlh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      pwlh_pkg::ST_CLEAR: cmd_o.clr_we = 1'b1;
      pwlh_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.accept    = in_valid_i;
        cmd_o.clr_start = in_valid_i && (in_op_i == pwlh_pkg::OP_CLEAR);
      end
      pwlh_pkg::ST_RDDATA: cmd_o.load_count = 1'b1;
      pwlh_pkg::ST_BLEN:   cmd_o.blen_en = 1'b1;
      pwlh_pkg::ST_BIN:    cmd_o.rd_bin = 1'b1;
      pwlh_pkg::ST_INC:    cmd_o.inc = 1'b1;
      pwlh_pkg::ST_HEIGHT: cmd_o.out_load = !stat_i.out_stall;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwlh_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: test/pulse_width_log_histogram_tb.sv
// Self-checking testbench for the pulse-width log histogram: random and directed stream traffic.
module pulse_width_log_histogram_tb;

  localparam int unsigned NBins      = pwlh_pkg::NumBinsDef;
  localparam int unsigned NumItems   = 1600;
  localparam int unsigned HoldAt     = 50;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    pwlh_pkg::op_e             op;
    logic [31:0]               word;
    logic [pwlh_pkg::BinW-1:0] bin;
    logic                      tsel;
    bit                        drain;
  } pulse_cmd_t;

  typedef struct {
    logic [31:0]                  count;
    logic [pwlh_pkg::HeightW-1:0] height;
  } bin_reading_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic                           s_ready;
  logic [pwlh_pkg::InTdataW-1:0]  s_tdata = '0;
  logic [pwlh_pkg::InTuserW-1:0]  s_tuser = '0;
  logic                           m_valid;
  logic                           m_ready = 1'b0;
  logic [pwlh_pkg::OutTdataW-1:0] m_tdata;

  pulse_cmd_t   pending_cmds[$];
  bin_reading_t expected_reads[$];
  pulse_cmd_t   cur_cmd;
  logic [31:0]  high_bins[NBins];
  logic [31:0]  low_bins[NBins];
  logic         phase_odd = 1'b0;
  logic [31:0]  hot_len[6];
  int unsigned  mismatches = 0;
  int unsigned  accepted = 0;
  int unsigned  results = 0;
  int unsigned  cycles = 0;
  int unsigned  gap_left = 0;
  int unsigned  rx_wait = 0;
  logic         drv_valid;
  logic         rx_ready;
  int unsigned  w;

  pulse_width_log_histogram dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  function automatic int unsigned bits_used(logic [31:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic int unsigned log_bin(logic [31:0] len);
    int unsigned b;
    b = bits_used(len);
    if (b >= 5) begin
      return b * 16 + ((len >> (b - 5)) & 32'h0f) - 64;
    end
    return len;
  endfunction

  function automatic logic [pwlh_pkg::HeightW-1:0] bar_of(logic [31:0] cnt);
    int unsigned b;
    int unsigned h;
    b = bits_used(cnt);
    if (b >= 3) begin
      h = b * 4 + ((cnt >> (b - 3)) & 32'h3) - 8;
    end else begin
      h = cnt;
    end
    h = h + 1;
    if (h > 100) begin
      h = 100;
    end
    return pwlh_pkg::HeightW'(h);
  endfunction

  task automatic track_histogram(pulse_cmd_t c);
    int unsigned bin;
    bin_reading_t r;
    case (c.op)
      pwlh_pkg::OP_ADD: begin
        bin = log_bin(32'd0 - c.word);
        if (bin >= pwlh_pkg::BinMin && bin < NBins) begin
          if (phase_odd) begin
            low_bins[bin] = low_bins[bin] + 1;
          end else begin
            high_bins[bin] = high_bins[bin] + 1;
          end
        end
        phase_odd = ~phase_odd;
      end
      pwlh_pkg::OP_READ: begin
        r.count = 32'd0;
        if (c.bin < NBins) begin
          r.count = c.tsel ? low_bins[c.bin] : high_bins[c.bin];
        end
        r.height = bar_of(r.count);
        expected_reads.push_back(r);
      end
      pwlh_pkg::OP_CLEAR: begin
        for (int i = 0; i < NBins; i++) begin
          high_bins[i] = 32'd0;
          low_bins[i] = 32'd0;
        end
        phase_odd = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", results, what, got, want);
    mismatches++;
  endtask

  task automatic push_cmd(pwlh_pkg::op_e op, logic [31:0] word,
                          logic [pwlh_pkg::BinW-1:0] bin, logic tsel, bit drain);
    pulse_cmd_t c;
    c.op = op;
    c.word = word;
    c.bin = bin;
    c.tsel = tsel;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic push_random(bit drain);
    int unsigned r;
    int unsigned b;
    int unsigned k;
    logic [31:0] len;
    logic [pwlh_pkg::BinW-1:0] bin;
    r = $urandom_range(0, 999);
    if (r < 10) begin
      push_cmd(pwlh_pkg::OP_CLEAR, $urandom, pwlh_pkg::BinW'($urandom), 1'($urandom), drain);
    end else if (r < 40) begin
      push_cmd(pwlh_pkg::OP_NONE, $urandom, pwlh_pkg::BinW'($urandom), 1'($urandom), drain);
    end else if (r < 560) begin
      if ($urandom_range(0, 9) < 6) begin
        len = hot_len[$urandom_range(0, 5)];
      end else begin
        b = $urandom_range(0, 32);
        len = (b == 0) ? 32'd0 : ((32'd1 << (b - 1)) | ($urandom & ((32'd1 << (b - 1)) - 1)));
      end
      push_cmd(pwlh_pkg::OP_ADD, 32'd0 - len, pwlh_pkg::BinW'($urandom), 1'($urandom), drain);
    end else begin
      k = $urandom_range(0, 9);
      if (k < 5) begin
        bin = pwlh_pkg::BinW'(log_bin(hot_len[$urandom_range(0, 5)]));
      end else if (k == 5) begin
        bin = pwlh_pkg::BinW'($urandom_range(0, pwlh_pkg::BinMin - 1));
      end else if (k == 6) begin
        bin = pwlh_pkg::BinW'($urandom_range(NBins, (1 << pwlh_pkg::BinW) - 1));
      end else begin
        bin = pwlh_pkg::BinW'($urandom);
      end
      push_cmd(pwlh_pkg::OP_READ, $urandom, bin, 1'($urandom), drain);
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      drv_valid = s_valid;
      if (s_valid && s_ready) begin
        track_histogram(cur_cmd);
        accepted++;
        drv_valid = 1'b0;
      end
      if (!drv_valid && pending_cmds.size() != 0) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (!(pending_cmds[0].drain && expected_reads.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          s_tdata <= pwlh_pkg::InTdataW'({cur_cmd.bin, cur_cmd.word});
          s_tuser <= {cur_cmd.tsel, cur_cmd.op};
          drv_valid = 1'b1;
          gap_left <= ((accepted / 150) % 3 == 0) ? 0 : $urandom_range(0, 10);
        end
      end
      s_valid <= drv_valid;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      rx_ready = m_ready;
      if (m_valid && m_ready) begin
        if (expected_reads.size() == 0) begin
          report_mismatch("unexpected result, bin_count", m_tdata[31:0], 0);
        end else begin
          if (m_tdata[31:0] !== expected_reads[0].count) begin
            report_mismatch("bin_count", m_tdata[31:0], expected_reads[0].count);
          end
          if (m_tdata[38:32] !== expected_reads[0].height) begin
            report_mismatch("bar_height", m_tdata[38:32], expected_reads[0].height);
          end
          void'(expected_reads.pop_front());
        end
        results++;
        if (results == HoldAt) begin
          w = HoldCycles;
        end else if ((results / 40) % 3 == 1) begin
          w = 0;
        end else begin
          w = $urandom_range(0, 10);
        end
        rx_wait <= w;
        rx_ready = (w == 0);
      end else if (!m_ready) begin
        if (rx_wait <= 1) begin
          rx_ready = 1'b1;
        end
        rx_wait <= (rx_wait == 0) ? 0 : rx_wait - 1;
      end
      m_ready <= rx_ready;
    end
  end

  initial begin
    int unsigned counted;
    for (int i = 0; i < NBins; i++) begin
      high_bins[i] = 32'd0;
      low_bins[i] = 32'd0;
    end
    hot_len[0] = 32'd5;
    hot_len[1] = 32'd17;
    hot_len[2] = 32'd40;
    hot_len[3] = 32'd1000;
    hot_len[4] = 32'h007f_ffff;
    hot_len[5] = $urandom_range(32, 1 << 22);

    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'hffff_ffff, 9'h1ff, 1'b1, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'h0000_0000, 9'h1ff, 1'b1, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'hffff_ffff, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'd5, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'd5, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'd31, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'd32, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'h007f_ffff, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'h0080_0000, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'h8000_0000, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'h0000_0001, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_NONE, $urandom, 9'd5, 1'b1, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd5, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd5, 1'b1, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd31, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd96, 1'b1, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd319, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd320, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd4, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_CLEAR, 32'd0, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd5, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_ADD, 32'd0 - 32'd5, 9'd0, 1'b0, 1'b0);
    push_cmd(pwlh_pkg::OP_READ, 32'd0, 9'd5, 1'b0, 1'b0);

    counted = 0;
    while (counted < NumItems) begin
      push_random(counted == NumItems / 2);
      if (pending_cmds[pending_cmds.size() - 1].op != pwlh_pkg::OP_NONE) begin
        counted++;
      end
    end

    while (!rst_ni || pending_cmds.size() != 0 || s_valid) begin
      @(posedge clk_i);
    end
    while (expected_reads.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
